// ===== rtl/double_ended_queue_assert.svh =====
// Assertion macros for the double-ended queue.
// Used by the top level; needs no other file.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("double_ended_queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("double_ended_queue: next-cycle check failed");

`endif

// ===== rtl/deq_pkg.sv =====
// Shared types and constants of the double-ended queue.
// No dependencies; compile first.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;

  // Per-cell move: take lower neighbour, take upper neighbour, or load
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== rtl/deq_if.sv =====
// Handshake interfaces for the request and response channels.
// Depends on deq_pkg.
`timescale 1ns / 1ps

interface deq_req_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             action;
  logic [deq_pkg::DATA_WIDTH-1:0] data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface deq_rsp_if;
  logic                   valid;
  logic                   ready;
  logic [deq_pkg::DATA_WIDTH-1:0] pop_value;
  logic                   pop_valid;
  logic [1:0]             status;
  logic                   is_empty;
  logic [deq_pkg::CNT_W-1:0]      occupancy;
  logic [deq_pkg::DATA_WIDTH-1:0] front_value;
  logic [deq_pkg::DATA_WIDTH-1:0] back_value;

  modport source (output valid, output pop_value, output pop_valid, output status,
                  output is_empty, output occupancy, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input pop_value, input pop_valid, input status,
                  input is_empty, input occupancy, input front_value,
                  input back_value, output ready);
endinterface

// ===== rtl/deq_cell.sv =====
// One storage cell of a queue row.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell (
  input  logic                clk,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  deq_pkg::word_t      lower_data,
  input  deq_pkg::word_t      upper_data,
  input  deq_pkg::word_t      load_data,
  output deq_pkg::word_t      data,
  output deq_pkg::word_t      data_next
);
  import deq_pkg::*;

  always_comb begin
    if (ctrl.shift_up) begin
      data_next = lower_data;
    end else if (ctrl.shift_down) begin
      data_next = upper_data;
    end else if (ctrl.load) begin
      data_next = load_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/deq_chain.sv =====
// A row of DEPTH cells with the head at cell 0.
// Depends on deq_pkg and deq_cell.
`timescale 1ns / 1ps

module deq_chain (
  input  logic                clk,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  deq_pkg::count_t     write_pos,
  input  deq_pkg::word_t      din,
  output deq_pkg::word_t      head,
  output deq_pkg::word_t      head_next
);
  import deq_pkg::*;

  word_t      cell_data [DEPTH];
  word_t      cell_next [DEPTH];
  cell_ctrl_t cell_ctrl [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lower;
    word_t upper;

    // Load only the cell one past the tail of this row
    always_comb begin
      cell_ctrl[i].shift_up   = ctrl.shift_up;
      cell_ctrl[i].shift_down = ctrl.shift_down;
      cell_ctrl[i].load       = ctrl.load && (write_pos == CNT_W'(i));
    end

    if (i == 0) begin : g_first
      assign lower = din;
    end else begin : g_mid
      assign lower = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_inner
      assign upper = cell_data[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .lower_data (lower),
      .upper_data (upper),
      .load_data  (din),
      .data       (cell_data[i]),
      .data_next  (cell_next[i])
    );
  end

  assign head      = cell_data[0];
  assign head_next = cell_next[0];

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: two cell rows, occupancy counter,
// response register. Depends on deq_pkg, deq_if, deq_chain and the assert header.
`timescale 1ns / 1ps
//
// Usage
//   req channel: one transaction carries an action (none, push front, push
//   back, pop front, pop back; codes 5 to 7 act as none) and a data word.
//   rsp channel: one transaction per request, with the popped word, its
//   valid mark, a status (ok, pop on empty, push on full), the empty flag,
//   the occupancy and the front and back words as they stand after it.
//   Response: registered; it appears in the cycle after the request transaction.
//   Throughput: one transaction per cycle unless the stall below holds it;
//   every action is one shift or load in the two cell rows, so nothing iterates.
//   Storage: two rows of DEPTH cells. The front row keeps the front word in
//   its first cell, the back row keeps the back word in its first cell; a
//   push at one end shifts that end's row and writes the other row at the
//   occupancy position, so both end words are always at fixed cells.
//   Reset: the occupancy and the response valid clear; cell contents are
//   left as they are and never read before a push fills them.
//   Stall: while a response waits unaccepted, req.ready is low and the
//   held response stays unchanged; it frees as soon as rsp.ready is high.
//
module double_ended_queue (
  input logic  clk,
  input logic  rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  count_t     count;
  count_t     count_next;
  cell_ctrl_t front_ctrl;
  cell_ctrl_t back_ctrl;
  word_t      front_head;
  word_t      front_head_next;
  word_t      back_head;
  word_t      back_head_next;

  logic    accept;
  logic    is_full;
  logic    is_void;
  logic    push_front_ok;
  logic    push_back_ok;
  logic    pop_front_ok;
  logic    pop_back_ok;
  status_t status_now;

  // Take a new request whenever the response register is free or draining
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign is_full = (count == CNT_W'(DEPTH));
  assign is_void = (count == '0);

  always_comb begin
    push_front_ok = 1'b0;
    push_back_ok  = 1'b0;
    pop_front_ok  = 1'b0;
    pop_back_ok   = 1'b0;
    status_now    = ST_OK;
    case (action_t'(req.action))
      ACT_PUSH_FRONT: begin
        if (is_full) status_now = ST_FULL;
        else         push_front_ok = accept;
      end
      ACT_PUSH_BACK: begin
        if (is_full) status_now = ST_FULL;
        else         push_back_ok = accept;
      end
      ACT_POP_FRONT: begin
        if (is_void) status_now = ST_EMPTY;
        else         pop_front_ok = accept;
      end
      ACT_POP_BACK: begin
        if (is_void) status_now = ST_EMPTY;
        else         pop_back_ok = accept;
      end
      default: status_now = ST_OK;
    endcase
  end

  // Each row: its own end shifts, pushes at the far end load at the count
  always_comb begin
    front_ctrl.shift_up   = push_front_ok;
    front_ctrl.shift_down = pop_front_ok;
    front_ctrl.load       = push_back_ok;
    back_ctrl.shift_up    = push_back_ok;
    back_ctrl.shift_down  = pop_back_ok;
    back_ctrl.load        = push_front_ok;
  end

  always_comb begin
    count_next = count;
    if (push_front_ok || push_back_ok) begin
      count_next = count + 1'b1;
    end else if (pop_front_ok || pop_back_ok) begin
      count_next = count - 1'b1;
    end
  end

  deq_chain u_front_row (
    .clk       (clk),
    .ctrl      (front_ctrl),
    .write_pos (count),
    .din       (req.data_in),
    .head      (front_head),
    .head_next (front_head_next)
  );

  deq_chain u_back_row (
    .clk       (clk),
    .ctrl      (back_ctrl),
    .write_pos (count),
    .din       (req.data_in),
    .head      (back_head),
    .head_next (back_head_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Response valid: raise on a request transaction, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Response payload: load with the transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.pop_valid <= pop_front_ok || pop_back_ok;
      if (pop_front_ok) begin
        rsp.pop_value <= front_head;
      end else if (pop_back_ok) begin
        rsp.pop_value <= back_head;
      end else begin
        rsp.pop_value <= '0;
      end
      rsp.status      <= status_now;
      rsp.is_empty    <= (count_next == '0);
      rsp.occupancy   <= count_next;
      rsp.front_value <= (count_next == '0) ? '0 : front_head_next;
      rsp.back_value  <= (count_next == '0) ? '0 : back_head_next;
    end
  end

  // Checks
`include "double_ended_queue_assert.svh"

  `DEQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `DEQ_ASSERT_NEXT(a_pop_empty, clk, rst, accept && is_void && (req.action == ACT_POP_FRONT || req.action == ACT_POP_BACK), rsp.status == ST_EMPTY && !rsp.pop_valid)
  `DEQ_ASSERT_NEXT(a_push_count, clk, rst, push_front_ok || push_back_ok, count == $past(count) + 1'b1)
  `DEQ_ASSERT_NOW(a_empty_views, clk, rst, rsp.valid && rsp.is_empty, rsp.front_value == '0 && rsp.back_value == '0)

endmodule
